>>> hw/rtl/tgrr_pkg.sv
// Shared types, register codes, palettes and constants of the text glyph row renderer.
// Used by tgrr_front, tgrr_emit, the top level and the testbench; depends on nothing.
`default_nettype none
package tgrr_pkg;

  localparam int GLYPH_COUNT      = 128;
  localparam int MAX_GLYPH_HEIGHT = 32;
  localparam int MAX_GLYPH_WIDTH  = 16;
  localparam int FONT_WIDTH       = 16;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [2:0] REG_FRAME_BASE   = 3'd0;
  localparam logic [2:0] REG_COLOR_DEPTH  = 3'd1;
  localparam logic [2:0] REG_ROW_PITCH    = 3'd2;
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd3;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd4;
  localparam logic [2:0] REG_TEXT_COLUMNS = 3'd5;
  localparam logic [2:0] REG_TEXT_ROWS    = 3'd6;

  typedef struct packed {
    logic [31:0] frame_base;
    logic [5:0]  color_depth;
    logic [15:0] row_pitch_bytes;
    logic [4:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [7:0]  text_columns;
    logic [6:0]  text_rows;
  } cfg_t;

  typedef struct packed {
    logic [31:0] base;
    logic [15:0] bits;
    logic [23:0] fg;
    logic [23:0] bg;
    logic [2:0]  bpp;
    logic        mono;
    logic [2:0]  pixoff;
    logic [4:0]  gw;
  } job_t;

  function automatic logic [23:0] palette_color(input logic [5:0] depth,
                                                input logic [2:0] idx,
                                                input logic [2:0] bpp);
    logic [23:0] v;
    v = 24'h000000;
    if (depth == 6'd8) begin
      case (idx)
        3'd0: v = 24'h00003f;
        3'd1: v = 24'h000020;
        3'd2: v = 24'h000034;
        3'd3: v = 24'h000046;
        3'd4: v = 24'h00002a;
        3'd5: v = 24'h000058;
        3'd6: v = 24'h000043;
        default: v = 24'h000000;
      endcase
    end else if (depth == 6'd15) begin
      case (idx)
        3'd0: v = 24'h007fff;
        3'd1: v = 24'h001993;
        3'd2: v = 24'h002660;
        3'd3: v = 24'h000273;
        3'd4: v = 24'h006400;
        3'd5: v = 24'h00390f;
        3'd6: v = 24'h006ea0;
        default: v = 24'h000000;
      endcase
    end else if (depth == 6'd16) begin
      case (idx)
        3'd0: v = 24'h00ffff;
        3'd1: v = 24'h003333;
        3'd2: v = 24'h004cc0;
        3'd3: v = 24'h0004d3;
        3'd4: v = 24'h00c800;
        3'd5: v = 24'h00722f;
        3'd6: v = 24'h00dd40;
        default: v = 24'h000000;
      endcase
    end else begin
      case (idx)
        3'd0: v = 24'hffffff;
        3'd1: v = 24'h336698;
        3'd2: v = 24'h4e9a00;
        3'd3: v = 24'h06989a;
        3'd4: v = 24'hcc0000;
        3'd5: v = 24'h73447b;
        3'd6: v = 24'hdaa800;
        default: v = 24'h000000;
      endcase
    end
    if (bpp == 3'd1) begin
      v = v & 24'h0000ff;
    end else if (bpp == 3'd2) begin
      v = v & 24'h00ffff;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tgrr_item_if.sv
// Input channel of the glyph row renderer: valid, ready and one load or render item.
// Depends on nothing.
`default_nettype none
interface tgrr_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  glyph;
  logic [7:0]  attr;
  logic [7:0]  column;
  logic [6:0]  text_row;
  logic [4:0]  line;
  logic [15:0] font_word;

  modport source (output valid, operation, glyph, attr, column, text_row, line, font_word,
                  input ready);
  modport sink (input valid, operation, glyph, attr, column, text_row, line, font_word,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tgrr_pixel_if.sv
// Output channel of the glyph row renderer: valid, ready and one frame-buffer write.
// Depends on nothing.
`default_nettype none
interface tgrr_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] byte_address;
  logic [23:0] pixel_value;
  logic [2:0]  byte_count;
  logic        mono_mode;
  logic [7:0]  bit_mask;
  logic        set_bit;
  logic        last;

  modport source (output valid, byte_address, pixel_value, byte_count, mono_mode, bit_mask,
                  set_bit, last, input ready);
  modport sink (input valid, byte_address, pixel_value, byte_count, mono_mode, bit_mask,
                set_bit, last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tgrr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none
module tgrr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tgrr_front.sv
// Front pipeline: takes items, writes and reads the font store, checks the cell and
// builds the line descriptor. Depends on tgrr_pkg, tgrr_item_if and tgrr_ram.
`default_nettype none
module tgrr_front #(
  parameter int GLYPH_COUNT      = tgrr_pkg::GLYPH_COUNT,
  parameter int MAX_GLYPH_HEIGHT = tgrr_pkg::MAX_GLYPH_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  tgrr_pkg::cfg_t    cfg,
  tgrr_item_if.sink         items,
  output logic              job_valid,
  output tgrr_pkg::job_t    job,
  input  logic              job_take
);

  localparam int Depth = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [7:0] GlyphMax = 8'(GLYPH_COUNT - 1);

  logic en;

  // stage 1
  logic        v1;
  logic        op1;
  logic [7:0]  glyph1;
  logic [7:0]  attr1;
  logic [7:0]  col1;
  logic [6:0]  trow1;
  logic [4:0]  line1;
  logic [15:0] word1;
  logic [4:0]  gwsat;
  logic [7:0]  g127;
  logic [7:0]  gsel;
  logic        line_in_store;
  logic        ok1;
  logic        store_wr;
  logic        store_rd;
  logic [AddrW-1:0] store_addr;
  logic [22:0] p1;
  logic [20:0] p2;
  logic [12:0] p3;

  // stage 2
  logic        v2;
  logic [22:0] p1_2;
  logic [20:0] p2_2;
  logic [12:0] p3_2;
  logic [7:0]  attr2;
  logic [5:0]  depth_sat;
  logic [2:0]  bpp2;
  logic        mono2;
  logic [31:0] q1;
  logic [31:0] sum_a;
  logic [31:0] colterm;
  logic [15:0] colprod;
  logic [23:0] fg2;
  logic [23:0] bg2;
  logic [15:0] rdata;

  // stage 3
  logic        v3;
  logic [31:0] q1_3;
  logic [31:0] sum_a3;
  logic [31:0] colterm3;
  logic [23:0] fg3;
  logic [23:0] bg3;
  logic [2:0]  bpp3;
  logic        mono3;
  logic [2:0]  pixoff3;
  logic [4:0]  gw2;
  logic [4:0]  gw3;
  logic [15:0] bits3;

  assign en = !v3 || job_take;
  assign items.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= items.valid;
    end
    if (en) begin
      op1    <= items.operation;
      glyph1 <= items.glyph;
      attr1  <= items.attr;
      col1   <= items.column;
      trow1  <= items.text_row;
      line1  <= items.line;
      word1  <= items.font_word;
    end
  end

  always_comb begin
    gwsat = (32'(cfg.glyph_width) > 32'(tgrr_pkg::MAX_GLYPH_WIDTH))
          ? 5'(tgrr_pkg::MAX_GLYPH_WIDTH) : cfg.glyph_width;
    g127  = (glyph1 > 8'd127) ? 8'd127 : glyph1;
    gsel  = (op1 == tgrr_pkg::OP_RENDER) ? ((g127 > GlyphMax) ? GlyphMax : g127) : glyph1;
    line_in_store = 32'(line1) < 32'(MAX_GLYPH_HEIGHT);
    store_addr = AddrW'(32'(gsel) * 32'(MAX_GLYPH_HEIGHT) + 32'(line1));
    ok1 = v1 && (op1 == tgrr_pkg::OP_RENDER)
       && (col1 < cfg.text_columns) && (trow1 < cfg.text_rows)
       && (cfg.frame_base != 32'd0)
       && ({1'b0, line1} < cfg.glyph_height) && line_in_store
       && (gwsat != 5'd0);
    store_wr = en && v1 && (op1 == tgrr_pkg::OP_LOAD)
            && (32'(glyph1) < 32'(GLYPH_COUNT)) && line_in_store;
    store_rd = en && v1 && (op1 == tgrr_pkg::OP_RENDER);
    p1 = 23'(cfg.row_pitch_bytes) * 23'(trow1);
    p2 = 21'(cfg.row_pitch_bytes) * 21'(line1);
    p3 = 13'(col1) * 13'(gwsat);
  end

  tgrr_ram #(
    .WIDTH (tgrr_pkg::FONT_WIDTH),
    .DEPTH (Depth)
  ) u_font (
    .clk   (clk),
    .we    (store_wr),
    .waddr (store_addr),
    .wdata (word1),
    .re    (store_rd),
    .raddr (store_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= ok1;
    end
    if (en) begin
      p1_2  <= p1;
      p2_2  <= p2;
      p3_2  <= p3;
      attr2 <= attr1;
      gw2   <= gwsat;
    end
  end

  always_comb begin
    depth_sat = (cfg.color_depth > 6'd32) ? 6'd32 : cfg.color_depth;
    bpp2      = 3'((7'(depth_sat) + 7'd7) >> 3);
    mono2     = cfg.color_depth < 6'd8;
    q1        = 32'(p1_2) * 32'(cfg.glyph_height);
    sum_a     = cfg.frame_base + 32'(p2_2);
    colprod   = 16'(p3_2) * 16'(bpp2);
    colterm   = mono2 ? 32'(p3_2[12:3]) : 32'(colprod);
    fg2       = tgrr_pkg::palette_color(cfg.color_depth, attr2[2:0], bpp2);
    bg2       = tgrr_pkg::palette_color(cfg.color_depth, attr2[6:4], bpp2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      q1_3     <= q1;
      sum_a3   <= sum_a;
      colterm3 <= colterm;
      fg3      <= fg2;
      bg3      <= bg2;
      bpp3     <= bpp2;
      mono3    <= mono2;
      pixoff3  <= p3_2[2:0];
      gw3      <= gw2;
      bits3    <= (cfg.glyph_width <= 5'd8) ? {8'h00, rdata[7:0]} : rdata;
    end
  end

  always_comb begin
    job_valid  = v3;
    job.base   = sum_a3 + q1_3 + colterm3;
    job.bits   = bits3;
    job.fg     = fg3;
    job.bg     = bg3;
    job.bpp    = bpp3;
    job.mono   = mono3;
    job.pixoff = pixoff3;
    job.gw     = gw3;
  end

endmodule
`default_nettype wire

>>> hw/rtl/tgrr_emit.sv
// Pixel sequencer: walks the glyph columns of one line descriptor, one write per cycle while
// the receiver takes them, into an output register. Depends on tgrr_pkg and tgrr_pixel_if.
`default_nettype none
module tgrr_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  tgrr_pkg::job_t job,
  output logic           job_take,
  tgrr_pixel_if.source   pixels
);

  tgrr_pkg::job_t cur;
  logic        busy;
  logic [4:0]  x;
  logic        step;
  logic        last_px;
  logic        px_bit;
  logic [4:0]  off;
  logic [7:0]  xprod;

  logic        ov;
  logic [31:0] addr_q;
  logic [23:0] value_q;
  logic [2:0]  count_q;
  logic        mono_q;
  logic [7:0]  mask_q;
  logic        set_q;
  logic        last_q;

  assign step     = busy && (!ov || pixels.ready);
  assign last_px  = x == (cur.gw - 5'd1);
  assign job_take = !busy || (step && last_px);
  assign px_bit   = cur.bits[x[3:0]];
  assign off      = 5'(cur.pixoff) + x;
  assign xprod    = 8'(x) * 8'(cur.bpp);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      x    <= 5'd0;
    end else if (job_valid && job_take) begin
      busy <= 1'b1;
      x    <= 5'd0;
    end else if (step && last_px) begin
      busy <= 1'b0;
    end else if (step) begin
      x <= x + 5'd1;
    end
    if (job_valid && job_take) begin
      cur <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (step) begin
      ov <= 1'b1;
    end else if (pixels.ready) begin
      ov <= 1'b0;
    end
    if (step) begin
      last_q <= last_px;
      mono_q <= cur.mono;
      if (cur.mono) begin
        addr_q  <= cur.base + 32'(off[4:3]);
        value_q <= 24'd0;
        count_q <= 3'd1;
        mask_q  <= 8'h80 >> off[2:0];
        set_q   <= !px_bit;
      end else begin
        addr_q  <= cur.base + 32'(xprod);
        value_q <= px_bit ? cur.fg : cur.bg;
        count_q <= cur.bpp;
        mask_q  <= 8'h00;
        set_q   <= 1'b0;
      end
    end
  end

  assign pixels.valid        = ov;
  assign pixels.byte_address = addr_q;
  assign pixels.pixel_value  = value_q;
  assign pixels.byte_count   = count_q;
  assign pixels.mono_mode    = mono_q;
  assign pixels.bit_mask     = mask_q;
  assign pixels.set_bit      = set_q;
  assign pixels.last         = last_q;

endmodule
`default_nettype wire

>>> hw/rtl/text_glyph_row_renderer_core.sv
// Top level of the text glyph row renderer: configuration registers, front pipeline
// and pixel sequencer. Depends on tgrr_pkg, both channel interfaces, tgrr_front, tgrr_emit.
//
// items (valid/ready): load items write one font row; render items name a text cell,
//   glyph, attribute and scan line. A transfer happens when valid and ready are high.
// pixels (valid/ready): one frame-buffer write per glyph column, last on the final one.
// cfg_we/cfg_index/cfg_data: register writes, taken at any edge with cfg_we high and rst low.
// Throughput: one pixel write per cycle while pixels.ready allows it, so a render item
//   occupies the sequencer for one write per glyph column (glyph_width, saturated at 16);
//   loads and cells that give nothing leave the pipeline and cost no sequencer time.
// Path: with the sequencer idle, the first write of a line reaches pixels through the
//   item register, front stages two and three (font store read, address sum), the
//   sequencer's line register, then the output register.
// A new item is taken while the sequencer walks the previous line, until stage three holds a waiting line.
// Reset: empties the pipeline and output register and loads the register defaults;
//   the font store keeps its contents and must be loaded before use.
// Receiver stall: the output register holds, the sequencer halts, and the front pipeline
//   halts with items.ready low once stage three holds a waiting line descriptor.
`default_nettype none
module text_glyph_row_renderer_core #(
  parameter int GLYPH_COUNT      = tgrr_pkg::GLYPH_COUNT,
  parameter int MAX_GLYPH_HEIGHT = tgrr_pkg::MAX_GLYPH_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  tgrr_item_if.sink   items,
  tgrr_pixel_if.source pixels
);

  tgrr_pkg::cfg_t cfg;
  tgrr_pkg::job_t job;
  logic           job_valid;
  logic           job_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_base      <= 32'd0;
      cfg.color_depth     <= 6'd32;
      cfg.row_pitch_bytes <= 16'd4096;
      cfg.glyph_width     <= 5'd8;
      cfg.glyph_height    <= 6'd16;
      cfg.text_columns    <= 8'd128;
      cfg.text_rows       <= 7'd48;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgrr_pkg::REG_FRAME_BASE:   cfg.frame_base      <= cfg_data;
        tgrr_pkg::REG_COLOR_DEPTH:  cfg.color_depth     <= cfg_data[5:0];
        tgrr_pkg::REG_ROW_PITCH:    cfg.row_pitch_bytes <= cfg_data[15:0];
        tgrr_pkg::REG_GLYPH_WIDTH:  cfg.glyph_width     <= cfg_data[4:0];
        tgrr_pkg::REG_GLYPH_HEIGHT: cfg.glyph_height    <= cfg_data[5:0];
        tgrr_pkg::REG_TEXT_COLUMNS: cfg.text_columns    <= cfg_data[7:0];
        tgrr_pkg::REG_TEXT_ROWS:    cfg.text_rows       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  tgrr_front #(
    .GLYPH_COUNT      (GLYPH_COUNT),
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .items     (items),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  tgrr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .pixels    (pixels)
  );

endmodule
`default_nettype wire

>>> hw/rtl/tgrr_checker.sv
// Port-level checks of the glyph row renderer, attached to the top level by bind.
// Depends on text_glyph_row_renderer_core.
`default_nettype none
module tgrr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] byte_address,
  input logic [23:0] pixel_value,
  input logic [2:0]  byte_count,
  input logic        mono_mode,
  input logic [7:0]  bit_mask,
  input logic        set_bit,
  input logic        last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pixel output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_address)
      && $stable(pixel_value) && $stable(bit_mask) && $stable(set_bit) && $stable(last))
    else $error("stalled pixel write changed");

  a_mono_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && mono_mode |-> byte_count == 3'd1 && pixel_value == 24'd0
      && $onehot(bit_mask))
    else $error("malformed monochrome write");

  a_colour_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mono_mode |-> bit_mask == 8'd0 && !set_bit
      && byte_count != 3'd0 && byte_count <= 3'd4)
    else $error("malformed colour write");

endmodule

bind text_glyph_row_renderer_core tgrr_checker u_tgrr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (pixels.valid),
  .out_ready    (pixels.ready),
  .byte_address (pixels.byte_address),
  .pixel_value  (pixels.pixel_value),
  .byte_count   (pixels.byte_count),
  .mono_mode    (pixels.mono_mode),
  .bit_mask     (pixels.bit_mask),
  .set_bit      (pixels.set_bit),
  .last         (pixels.last)
);
`default_nettype wire

>>> tb/tgrr_write_checker.sv
// Scoreboard of the glyph row renderer: mirrors the font store and the registers, works out
// every frame-buffer write of each render transfer and compares it with the pixel channel.
// Depends on tgrr_pkg, tgrr_item_if and tgrr_pixel_if.
`timescale 1ns / 1ps
module tgrr_write_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  tgrr_item_if        items,
  tgrr_pixel_if       pixels,
  output int          mismatches,
  output int          writes_owed
);
  import tgrr_pkg::*;

  typedef struct packed {
    logic [31:0] byte_address;
    logic [23:0] pixel_value;
    logic [2:0]  byte_count;
    logic        mono_mode;
    logic [7:0]  bit_mask;
    logic        set_bit;
    logic        last;
  } fb_write_t;

  localparam logic [63:0]  SHADES_8BPP  = 64'h0043582a4634203f;
  localparam logic [127:0] SHADES_15BPP = 128'h0000_6ea0_390f_6400_0273_2660_1993_7fff;
  localparam logic [127:0] SHADES_16BPP = 128'h0000_dd40_722f_c800_04d3_4cc0_3333_ffff;
  localparam logic [191:0] SHADES_24BPP =
    192'h000000_daa800_73447b_cc0000_06989a_4e9a00_336698_ffffff;

  cfg_t        regs;
  logic [15:0] font_rows [GLYPH_COUNT * MAX_GLYPH_HEIGHT];
  fb_write_t   writes_due [$];

  function automatic logic [23:0] shade(input logic [5:0] depth, input logic [2:0] idx,
                                        input int unsigned nbytes);
    logic [23:0] v;
    case (depth)
      6'd8:    v = {16'h0000, SHADES_8BPP[idx * 8 +: 8]};
      6'd15:   v = {8'h00, SHADES_15BPP[idx * 16 +: 16]};
      6'd16:   v = {8'h00, SHADES_16BPP[idx * 16 +: 16]};
      default: v = SHADES_24BPP[idx * 24 +: 24];
    endcase
    if (nbytes < 3) v = v & ((24'h1 << (8 * nbytes)) - 24'h1);
    return v;
  endfunction

  task automatic render_line(input logic [7:0] glyph, input logic [7:0] attr,
                             input logic [7:0] column, input logic [6:0] text_row,
                             input logic [4:0] line);
    int unsigned g, gw, depth, nbytes, base, pix, off, x;
    logic [15:0] bits;
    logic [23:0] fg, bg;
    fb_write_t   w;
    g = (glyph > 8'd127) ? 127 : glyph;
    if (g > GLYPH_COUNT - 1) g = GLYPH_COUNT - 1;
    if (column >= regs.text_columns || text_row >= regs.text_rows || regs.frame_base == 0)
      return;
    if (line >= regs.glyph_height || line >= MAX_GLYPH_HEIGHT) return;
    gw = (regs.glyph_width > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : regs.glyph_width;
    if (gw == 0) return;
    bits = font_rows[g * MAX_GLYPH_HEIGHT + line];
    if (regs.glyph_width <= 8) bits[15:8] = 8'h00;
    base = regs.frame_base + regs.row_pitch_bytes * text_row * regs.glyph_height
         + regs.row_pitch_bytes * line;
    w = '0;
    if (regs.color_depth >= 6'd8) begin
      depth  = (regs.color_depth > 6'd32) ? 32 : regs.color_depth;
      nbytes = (depth + 7) / 8;
      fg     = shade(regs.color_depth, attr[2:0], nbytes);
      bg     = shade(regs.color_depth, attr[6:4], nbytes);
      base   = base + column * gw * nbytes;
      for (x = 0; x < gw; x++) begin
        w.byte_address = base + x * nbytes;
        w.pixel_value  = bits[x] ? fg : bg;
        w.byte_count   = 3'(nbytes);
        w.last         = (x + 1 == gw);
        writes_due.push_back(w);
      end
    end else begin
      pix  = column * gw;
      base = base + pix / 8;
      for (x = 0; x < gw; x++) begin
        off            = (pix % 8) + x;
        w.byte_address = base + off / 8;
        w.byte_count   = 3'd1;
        w.mono_mode    = 1'b1;
        w.bit_mask     = 8'h80 >> (off % 8);
        w.set_bit      = !bits[x];
        w.last         = (x + 1 == gw);
        writes_due.push_back(w);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    fb_write_t want;
    if (rst) begin
      regs = '{32'h0, 6'd32, 16'd4096, 5'd8, 6'd16, 8'd128, 7'd48};
      writes_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_BASE:   regs.frame_base      = cfg_data;
          REG_COLOR_DEPTH:  regs.color_depth     = cfg_data[5:0];
          REG_ROW_PITCH:    regs.row_pitch_bytes = cfg_data[15:0];
          REG_GLYPH_WIDTH:  regs.glyph_width     = cfg_data[4:0];
          REG_GLYPH_HEIGHT: regs.glyph_height    = cfg_data[5:0];
          REG_TEXT_COLUMNS: regs.text_columns    = cfg_data[7:0];
          REG_TEXT_ROWS:    regs.text_rows       = cfg_data[6:0];
          default: ;
        endcase
      end
      if (items.valid && items.ready) begin
        if (items.operation == OP_LOAD) begin
          if (items.glyph < GLYPH_COUNT)
            font_rows[items.glyph * MAX_GLYPH_HEIGHT + items.line] = items.font_word;
        end else begin
          render_line(items.glyph, items.attr, items.column, items.text_row, items.line);
        end
      end
      if (pixels.valid && pixels.ready) begin
        if (writes_due.size() == 0) begin
          $error("unexpected frame-buffer write to 0x%0h", pixels.byte_address);
          mismatches++;
        end else begin
          want = writes_due.pop_front();
          compare_field("byte_address", want.byte_address, pixels.byte_address);
          compare_field("pixel_value", want.pixel_value, pixels.pixel_value);
          compare_field("byte_count", want.byte_count, pixels.byte_count);
          compare_field("mono_mode", want.mono_mode, pixels.mono_mode);
          compare_field("bit_mask", want.bit_mask, pixels.bit_mask);
          compare_field("set_bit", want.set_bit, pixels.set_bit);
          compare_field("last", want.last, pixels.last);
        end
      end
    end
    writes_owed = writes_due.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the glyph row renderer testbench: clock, reset, register writes, item stimulus
// and the pixel receiver; the scoreboard beside the block does the checking.
// Depends on tgrr_pkg, both channel interfaces, the core and tgrr_write_checker.
`timescale 1ns / 1ps
module tb_top;

  localparam int ITEMS_PER_PHASE = 38;
  localparam int PHASES          = 10;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 2000;

  typedef struct packed {
    logic        operation;
    logic [7:0]  glyph;
    logic [7:0]  attr;
    logic [7:0]  column;
    logic [6:0]  text_row;
    logic [4:0]  line;
    logic [15:0] font_word;
  } glyph_item_t;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [2:0]      cfg_index;
  logic [31:0]     cfg_data;
  logic            sink_hold;
  logic            sink_idle;
  logic            source_idle;
  int              mismatches;
  int              writes_owed;
  int              items_sent;
  int              quiet_cycles;
  int              sink_wait;
  bit              row_loaded [tgrr_pkg::GLYPH_COUNT * tgrr_pkg::MAX_GLYPH_HEIGHT];
  int              loaded_rows [$];
  tgrr_pkg::cfg_t  shadow;
  tgrr_pkg::cfg_t  settings [PHASES];

  tgrr_item_if  items_ch ();
  tgrr_pixel_if pixels_ch ();

  text_glyph_row_renderer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_ch),
    .pixels    (pixels_ch)
  );

  tgrr_write_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .items       (items_ch),
    .pixels      (pixels_ch),
    .mismatches  (mismatches),
    .writes_owed (writes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic offer(input glyph_item_t it);
    int gap;
    int idx;
    gap = source_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid     <= 1'b1;
    items_ch.operation <= it.operation;
    items_ch.glyph     <= it.glyph;
    items_ch.attr      <= it.attr;
    items_ch.column    <= it.column;
    items_ch.text_row  <= it.text_row;
    items_ch.line      <= it.line;
    items_ch.font_word <= it.font_word;
    do @(posedge clk); while (!items_ch.ready);
    items_sent++;
    idx = it.glyph * tgrr_pkg::MAX_GLYPH_HEIGHT + it.line;
    if (it.operation == tgrr_pkg::OP_LOAD && it.glyph < tgrr_pkg::GLYPH_COUNT
        && !row_loaded[idx]) begin
      row_loaded[idx] = 1'b1;
      loaded_rows.push_back(idx);
    end
  endtask

  task automatic load_row(input logic [7:0] glyph, input logic [4:0] line,
                          input logic [15:0] word);
    offer('{tgrr_pkg::OP_LOAD, glyph, 8'h00, 8'h00, 7'h00, line, word});
  endtask

  task automatic render_cell(input logic [7:0] glyph, input logic [4:0] line,
                             input logic [7:0] attr, input logic [7:0] column,
                             input logic [6:0] text_row);
    offer('{tgrr_pkg::OP_RENDER, glyph, attr, column, text_row, line, 16'h0000});
  endtask

  task automatic random_item();
    glyph_item_t it;
    int          row;
    it.attr      = 8'($urandom_range(0, 255));
    it.column    = 8'($urandom_range(0, 255));
    it.text_row  = 7'($urandom_range(0, 127));
    it.line      = 5'($urandom_range(0, 31));
    it.font_word = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) < 3 || loaded_rows.size() == 0) begin
      it.operation = tgrr_pkg::OP_LOAD;
      case ($urandom_range(0, 9))
        0:       it.glyph = 8'($urandom_range(128, 255));
        1:       it.glyph = 8'd127;
        default: it.glyph = 8'($urandom_range(0, 127));
      endcase
    end else begin
      it.operation = tgrr_pkg::OP_RENDER;
      row          = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
      it.glyph     = 8'(row / tgrr_pkg::MAX_GLYPH_HEIGHT);
      it.line      = 5'(row % tgrr_pkg::MAX_GLYPH_HEIGHT);
      if (it.glyph == 8'd127 && $urandom_range(0, 1))
        it.glyph = 8'($urandom_range(128, 255));
      if (shadow.text_columns != 0 && $urandom_range(0, 9) != 0)
        it.column = 8'($urandom_range(0, shadow.text_columns - 1));
      if (shadow.text_rows != 0 && $urandom_range(0, 9) != 0)
        it.text_row = 7'($urandom_range(0, shadow.text_rows - 1));
    end
    offer(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_setting(input tgrr_pkg::cfg_t c);
    write_reg(tgrr_pkg::REG_FRAME_BASE, c.frame_base);
    write_reg(tgrr_pkg::REG_COLOR_DEPTH, 32'(c.color_depth));
    write_reg(tgrr_pkg::REG_ROW_PITCH, 32'(c.row_pitch_bytes));
    write_reg(tgrr_pkg::REG_GLYPH_WIDTH, 32'(c.glyph_width));
    write_reg(tgrr_pkg::REG_GLYPH_HEIGHT, 32'(c.glyph_height));
    write_reg(tgrr_pkg::REG_TEXT_COLUMNS, 32'(c.text_columns));
    write_reg(tgrr_pkg::REG_TEXT_ROWS, 32'(c.text_rows));
    cfg_we <= 1'b0;
    shadow = c;
  endtask

  task automatic drain();
    items_ch.valid <= 1'b0;
    do @(negedge clk); while (writes_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random back-pressure per transfer while sink_idle is set, forced low during the long hold
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      pixels_ch.ready <= 1'b0;
      sink_wait       <= 0;
    end else if (sink_hold) begin
      pixels_ch.ready <= 1'b0;
    end else if (pixels_ch.valid && pixels_ch.ready) begin
      gap = sink_idle ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
        pixels_ch.ready <= 1'b0;
        sink_wait       <= gap - 1;
      end
    end else if (!pixels_ch.ready) begin
      if (sink_wait == 0) pixels_ch.ready <= 1'b1;
      else sink_wait <= sink_wait - 1;
    end
  end

  // hold off the receiver mid-run so the pipeline fills and stalls the input
  initial begin
    sink_hold = 1'b0;
    wait (items_sent >= 40);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) || (pixels_ch.valid && pixels_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("text_glyph_row_renderer_core test failed");
        $finish;
      end
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    items_ch.valid     = 1'b0;
    items_ch.operation = tgrr_pkg::OP_LOAD;
    items_ch.glyph     = '0;
    items_ch.attr      = '0;
    items_ch.column    = '0;
    items_ch.text_row  = '0;
    items_ch.line      = '0;
    items_ch.font_word = '0;
    sink_idle          = 1'b1;
    source_idle        = 1'b1;
    items_sent         = 0;
    shadow      = '{32'h0, 6'd32, 16'd4096, 5'd8, 6'd16, 8'd128, 7'd48};
    settings[0] = '{32'hFFFF_FF00, 6'd32, 16'hFFFF, 5'd16, 6'd32, 8'd255, 7'd127};
    settings[1] = '{32'h0000_0001, 6'd8, 16'd1, 5'd8, 6'd16, 8'd80, 7'd25};
    settings[2] = '{32'h8000_0000, 6'd15, 16'd0, 5'd9, 6'd1, 8'd200, 7'd100};
    settings[3] = '{32'h1234_5678, 6'd16, 16'd320, 5'd1, 6'd63, 8'd40, 7'd12};
    settings[4] = '{32'h0A00_0000, 6'd1, 16'd80, 5'd8, 6'd16, 8'd80, 7'd30};
    settings[5] = '{32'hFFFF_FFFF, 6'd7, 16'd4095, 5'd13, 6'd24, 8'd19, 7'd7};
    settings[6] = '{32'h2000_0000, 6'd0, 16'd100, 5'd31, 6'd20, 8'd10, 7'd5};
    settings[7] = '{32'h3000_0000, 6'd24, 16'd3000, 5'd5, 6'd8, 8'd50, 7'd20};
    settings[8] = '{32'h4000_0000, 6'd63, 16'd5000, 5'd12, 6'd10, 8'd30, 7'd10};
    settings[9] = '{32'h5000_0000, 6'd32, 16'd2048, 5'd0, 6'd0, 8'd0, 7'd0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    load_row(8'd0, 5'd0, 16'hFFFF);
    load_row(8'd0, 5'd1, 16'h0000);
    load_row(8'd0, 5'd2, 16'hA5C3);
    load_row(8'd0, 5'd3, 16'h5A3C);
    load_row(8'd127, 5'd0, 16'h8001);
    load_row(8'd127, 5'd1, 16'h00FF);
    load_row(8'd127, 5'd31, 16'hFF00);
    load_row(8'd65, 5'd31, 16'h1234);
    load_row(8'd200, 5'd5, 16'hFFFF);
    render_cell(8'd0, 5'd0, 8'h70, 8'd0, 7'd0);
    drain();
    write_reg(tgrr_pkg::REG_FRAME_BASE, 32'h1000_0000);
    cfg_we <= 1'b0;
    shadow.frame_base = 32'h1000_0000;
    render_cell(8'd0, 5'd0, 8'h70, 8'd0, 7'd0);
    render_cell(8'd0, 5'd2, 8'hFF, 8'd127, 7'd47);
    render_cell(8'd0, 5'd3, 8'h15, 8'd128, 7'd0);
    render_cell(8'd0, 5'd1, 8'h26, 8'd5, 7'd48);
    render_cell(8'd65, 5'd31, 8'h34, 8'd3, 7'd3);
    render_cell(8'd255, 5'd1, 8'h52, 8'd9, 7'd20);
    render_cell(8'd128, 5'd0, 8'h61, 8'd64, 7'd10);
    render_cell(8'd127, 5'd0, 8'h43, 8'd1, 7'd1);
    render_cell(8'd127, 5'd1, 8'h07, 8'd255, 7'd127);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      apply_setting(settings[p]);
      source_idle = ($urandom_range(0, 3) != 0);
      sink_idle   = ($urandom_range(0, 3) != 0);
      repeat ((p == PHASES - 1) ? 12 : ITEMS_PER_PHASE) random_item();
    end
    drain();

    if (mismatches == 0 && writes_owed == 0) begin
      $display("text_glyph_row_renderer_core test passed");
    end else begin
      $display("text_glyph_row_renderer_core test failed");
    end
    $finish;
  end

endmodule

>>> text_glyph_row_renderer_core.f
hw/rtl/tgrr_pkg.sv
hw/rtl/tgrr_item_if.sv
hw/rtl/tgrr_pixel_if.sv
hw/rtl/tgrr_ram.sv
hw/rtl/tgrr_front.sv
hw/rtl/tgrr_emit.sv
hw/rtl/text_glyph_row_renderer_core.sv
hw/rtl/tgrr_checker.sv
tb/tgrr_write_checker.sv
tb/tb_top.sv
